// File: src/indexed_list_store_defines.svh
// Assertion macros used by the checker file of the indexed list store.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ILS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ils_pkg.sv
// Types and constants shared by the indexed list store modules.
package ils_pkg;

    localparam int SLOTS     = 16;
    localparam int ELEM_BITS = 32;
    localparam int CMD_BITS  = 3;
    localparam int POS_BITS  = 5;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 40;

    typedef logic [ELEM_BITS-1:0] elem_t;
    typedef logic [POS_BITS-1:0]  pos_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_APPEND = 3'd0,
        CMD_SET    = 3'd1,
        CMD_GET    = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    // Control broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic wr;          // write the new element at wr_pos
        pos_t wr_pos;
        logic shift_up;    // cells above pos take their lower neighbor's element
        logic shift_down;  // cells from pos up take their upper neighbor's element
        pos_t pos;         // index of the word
        pos_t fill;        // element count before the word
    } cell_ctl_t;

endpackage

// File: src/indexed_list_store.sv
// A result word is registered and appears in the cycle after its command word is accepted.
// Throughput: one command per cycle; every cell of the slot chain updates at once,
// so an insert or remove shifts the whole list as its command word is accepted.
// The input stalls only while a finished result waits and the output is not ready.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result;
// slot contents are not cleared and are never read before they are written.
module indexed_list_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[2:0], index[7:3], element[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], value[32:1], count[37:33], zero[39:38]
);

    // The list lives in a row of cells, one per slot. Cell i holds element i.
    // Each cycle the controller broadcasts one control word and every cell picks
    // its next element: the new element, its lower neighbor's (insert shifts up),
    // its upper neighbor's (remove shifts down), or its own.

    ils_pkg::cell_ctl_t ctl;
    ils_pkg::elem_t     cell_data [ils_pkg::SLOTS];
    ils_pkg::elem_t     cell_rd   [ils_pkg::SLOTS];
    ils_pkg::elem_t     rd_data;
    ils_pkg::elem_t     elem;
    logic               res_ok;
    ils_pkg::elem_t     res_value;
    ils_pkg::pos_t      res_count;

    assign elem = s_tdata[39:8];

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tdata[2:0]),
        .index     (s_tdata[7:3]),
        .rd_data   (rd_data),
        .ctl       (ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ok        (res_ok),
        .value     (res_value),
        .count     (res_count)
    );

    // The end cells have no neighbor on one side; those inputs are never selected.
    for (genvar i = 0; i < ils_pkg::SLOTS; i++)
    begin : g_cell
        ils_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .elem       (elem),
            .lower_data ((i == 0) ? elem : cell_data[(i == 0) ? 0 : i - 1]),
            .upper_data ((i == ils_pkg::SLOTS - 1) ? cell_data[i]
                         : cell_data[(i == ils_pkg::SLOTS - 1) ? i : i + 1]),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Only the cell whose position matches the index drives a nonzero read word,
    // so the read is an OR over the row.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < ils_pkg::SLOTS; i++)
        begin
            rd_data = rd_data | cell_rd[i];
        end
    end

    assign m_tdata = {2'b00, res_count, res_value, res_ok};

endmodule

// File: src/ils_cell.sv
// One slot of the list: holds an element and moves it to or from its neighbors.
module ils_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               clk,
    input  ils_pkg::cell_ctl_t ctl,
    input  ils_pkg::elem_t     elem,
    input  ils_pkg::elem_t     lower_data,
    input  ils_pkg::elem_t     upper_data,
    output ils_pkg::elem_t     data,
    output ils_pkg::elem_t     rd_data
);

    localparam ils_pkg::pos_t MY_POS = ils_pkg::POS_BITS'(CELL_IDX);
    localparam ils_pkg::pos_t MY_NXT = ils_pkg::POS_BITS'(CELL_IDX + 1);

    ils_pkg::elem_t data_reg;
    ils_pkg::elem_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr && (ctl.wr_pos == MY_POS))
        begin
            data_next = elem;
        end
        else if (ctl.shift_up && (MY_POS > ctl.pos) && (MY_POS <= ctl.fill))
        begin
            data_next = lower_data;
        end
        else if (ctl.shift_down && (MY_POS >= ctl.pos) && (MY_NXT < ctl.fill))
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (ctl.pos == MY_POS) ? data_reg : '0;

endmodule

// File: src/ils_ctrl.sv
// Command decode, element count and registered result word of the list store.
module ils_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ils_pkg::CMD_BITS-1:0]   command,
    input  ils_pkg::pos_t                  index,
    input  ils_pkg::elem_t                 rd_data,
    output ils_pkg::cell_ctl_t             ctl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output ils_pkg::elem_t                 value,
    output ils_pkg::pos_t                  count
);

    localparam ils_pkg::pos_t SLOTS_POS = ils_pkg::POS_BITS'(ils_pkg::SLOTS);
    localparam ils_pkg::pos_t POS_ONE   = ils_pkg::POS_BITS'(1);

    logic           fill_en;
    ils_pkg::pos_t  fill_reg;
    ils_pkg::pos_t  fill_next;
    logic           out_valid_reg;
    logic           ok_reg;
    logic           ok_next;
    ils_pkg::elem_t value_reg;
    ils_pkg::elem_t value_next;
    ils_pkg::pos_t  count_reg;
    logic           accept;
    logic           idx_ok;
    logic           not_full;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign idx_ok   = index < fill_reg;
    assign not_full = fill_reg < SLOTS_POS;

    always_comb
    begin
        ctl.wr         = 1'b0;
        ctl.wr_pos     = index;
        ctl.shift_up   = 1'b0;
        ctl.shift_down = 1'b0;
        ctl.pos        = index;
        ctl.fill       = fill_reg;
        ok_next        = 1'b0;
        value_next     = '0;
        fill_en        = 1'b0;
        fill_next      = fill_reg;
        case (ils_pkg::cmd_t'(command))
            ils_pkg::CMD_APPEND:
            begin
                ok_next    = not_full;
                ctl.wr     = accept && not_full;
                ctl.wr_pos = fill_reg;
                fill_next  = not_full ? fill_reg + POS_ONE : fill_reg;
            end
            ils_pkg::CMD_SET:
            begin
                ok_next = idx_ok;
                ctl.wr  = accept && idx_ok;
            end
            ils_pkg::CMD_GET:
            begin
                ok_next    = idx_ok;
                value_next = idx_ok ? rd_data : '0;
            end
            ils_pkg::CMD_INSERT:
            begin
                ok_next      = not_full && (index <= fill_reg);
                ctl.wr       = accept && ok_next;
                ctl.shift_up = accept && ok_next;
                fill_next    = ok_next ? fill_reg + POS_ONE : fill_reg;
            end
            ils_pkg::CMD_REMOVE:
            begin
                ok_next        = idx_ok;
                value_next     = idx_ok ? rd_data : '0;
                ctl.shift_down = accept && idx_ok;
                fill_next      = idx_ok ? fill_reg - POS_ONE : fill_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        fill_en = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fill_en)
            begin
                fill_reg <= fill_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ok_next;
            value_reg <= value_next;
            count_reg <= fill_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign value     = value_reg;
    assign count     = count_reg;

endmodule

// File: src/ils_checker.sv
// Port-level checks of the indexed list store, bound to the top level.
`include "indexed_list_store_defines.svh"

module ils_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata
);

    localparam logic [4:0] SLOTS_POS = 5'(ils_pkg::SLOTS);

    // A waiting result word holds its value until it is taken.
    `ILS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // The count never goes past the number of slots.
    `ILS_ASSERT_SAME(a_count_max, clk, rst_n, m_tvalid, m_tdata[37:33] <= SLOTS_POS, "count exceeds slot number")

    // A failed command returns a zero value.
    `ILS_ASSERT_SAME(a_fail_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "failed command returned a value")

    // With no result pending, the block takes a new command word.
    `ILS_ASSERT_SAME(a_ready_idle, clk, rst_n, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
